### rtl/i2cbms_pkg.sv
// ----------------------------------------------------------------------------
// i2cbms_pkg
// types and constants of the i2c byte master sequencer
// ----------------------------------------------------------------------------
package i2cbms_pkg;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_ACK   = 3'd3,
    OP_NACK  = 3'd4,
    OP_WAIT  = 3'd5,
    OP_WRITE = 3'd6,
    OP_READ  = 3'd7
  } op_t;

  typedef enum logic [19:0] {
    PH_IDLE = 20'h00001,
    PH_ST1  = 20'h00002,
    PH_ST2  = 20'h00004,
    PH_SP1  = 20'h00008,
    PH_SP2  = 20'h00010,
    PH_AK1  = 20'h00020,
    PH_AK2  = 20'h00040,
    PH_AK3  = 20'h00080,
    PH_NK1  = 20'h00100,
    PH_NK2  = 20'h00200,
    PH_WA1  = 20'h00400,
    PH_WA2  = 20'h00800,
    PH_WA3  = 20'h01000,
    PH_TO1  = 20'h02000,
    PH_TO2  = 20'h04000,
    PH_WD   = 20'h08000,
    PH_WH   = 20'h10000,
    PH_WL   = 20'h20000,
    PH_RH   = 20'h40000,
    PH_RL   = 20'h80000
  } phase_t;

  localparam int DATA_W = 16;
  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef struct packed {
    logic [7:0] read_data;
    logic       error;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

### rtl/i2c_byte_master_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_byte_master_sequencer_core
// i2c master line sequencer: one scl/sda pin phase per transaction
// ----------------------------------------------------------------------------
// Each input transaction is one pin phase tick: a command (taken only when
// idle), the byte to write and the sampled sda level. It yields exactly one
// result transaction with the driven scl/sda levels, busy, done, error and
// the read byte. The phase sequencer updates in the cycle a transaction is
// accepted, so one transaction is taken per clock; results wait in a
// two-entry output register pair, and s_tready only drops when both are
// full. ack_timeout_limit is written through cfg_wr_en/cfg_wr_data.
module i2c_byte_master_sequencer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [i2cbms_pkg::DATA_W-1:0] s_tdata,  // write_data[7:0], sda_in[8], zero pad
  input  logic [2:0]                  s_tuser,  // operation[2:0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], error[4], read_data[12:5], pad
  output logic [i2cbms_pkg::DATA_W-1:0] m_tdata,
  input  logic                        cfg_wr_en,
  input  logic [7:0]                  cfg_wr_data
);
  import i2cbms_pkg::*;

  logic [7:0] ack_timeout_limit;
  phase_t     phase, phase_next;
  op_t        command_reg, command_reg_next;
  logic [2:0] bit_counter, bit_counter_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] wait_counter, wait_counter_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;

  op_t        op;
  logic [7:0] wdata;
  logic       sda_in;
  logic       done, err;
  logic [7:0] rdata;
  result_t    res;

  logic       out_valid, skid_valid;
  result_t    out_res, skid_res;
  logic       accept, take;

  assign op     = op_t'(s_tuser);
  assign wdata  = s_tdata[7:0];
  assign sda_in = s_tdata[8];

  always_comb begin
    phase_next        = phase;
    command_reg_next  = command_reg;
    bit_counter_next  = bit_counter;
    shift_reg_next    = shift_reg;
    wait_counter_next = wait_counter;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    done              = 1'b0;
    err               = 1'b0;
    rdata             = 8'd0;
    unique case (phase)
      PH_IDLE: begin
        if (op != OP_NONE) begin
          command_reg_next = op;
          unique case (op)
            OP_START: begin
              scl_level_next = 1'b1;
              sda_level_next = 1'b1;
              phase_next     = PH_ST1;
            end
            OP_STOP: begin
              scl_level_next = 1'b0;
              sda_level_next = 1'b0;
              phase_next     = PH_SP1;
            end
            OP_ACK: begin
              scl_level_next = 1'b0;
              phase_next     = PH_AK1;
            end
            OP_NACK: begin
              scl_level_next = 1'b0;
              sda_level_next = 1'b1;
              phase_next     = PH_NK1;
            end
            OP_WAIT: begin
              scl_level_next = 1'b0;
              phase_next     = PH_WA1;
            end
            OP_WRITE: begin
              scl_level_next   = 1'b0;
              shift_reg_next   = wdata;
              bit_counter_next = 3'd0;
              phase_next       = PH_WD;
            end
            OP_READ: begin
              scl_level_next   = 1'b0;
              sda_level_next   = 1'b1;
              shift_reg_next   = 8'd0;
              bit_counter_next = 3'd0;
              phase_next       = PH_RH;
            end
            default: ;
          endcase
        end
      end
      PH_ST1: begin
        if (!sda_in) begin
          done = 1'b1;
          err  = 1'b1;
        end else begin
          sda_level_next = 1'b0;
          phase_next     = PH_ST2;
        end
      end
      PH_ST2: begin
        done = 1'b1;
        if (sda_in) begin
          err = 1'b1;
        end else begin
          scl_level_next = 1'b0;
        end
      end
      PH_SP1: begin
        scl_level_next = 1'b1;
        phase_next     = PH_SP2;
      end
      PH_SP2: begin
        sda_level_next = 1'b1;
        done           = 1'b1;
      end
      PH_AK1: begin
        sda_level_next = 1'b0;
        phase_next     = PH_AK2;
      end
      PH_AK2: begin
        scl_level_next = 1'b1;
        phase_next     = PH_AK3;
      end
      PH_AK3: begin
        scl_level_next = 1'b0;
        done           = 1'b1;
      end
      PH_NK1: begin
        scl_level_next = 1'b1;
        phase_next     = PH_NK2;
      end
      PH_NK2: begin
        scl_level_next = 1'b0;
        done           = 1'b1;
      end
      PH_WA1: begin
        sda_level_next = 1'b1;
        phase_next     = PH_WA2;
      end
      PH_WA2: begin
        scl_level_next    = 1'b1;
        wait_counter_next = 8'd0;
        phase_next        = PH_WA3;
      end
      PH_WA3: begin
        priority if (!sda_in) begin
          scl_level_next = 1'b0;
          done           = 1'b1;
        end else if (wait_counter >= ack_timeout_limit) begin
          scl_level_next = 1'b0;
          sda_level_next = 1'b0;
          phase_next     = PH_TO1;
        end else begin
          wait_counter_next = wait_counter + 8'd1;
        end
      end
      PH_TO1: begin
        scl_level_next = 1'b1;
        phase_next     = PH_TO2;
      end
      PH_TO2: begin
        sda_level_next = 1'b1;
        done           = 1'b1;
        err            = 1'b1;
      end
      PH_WD: begin
        sda_level_next = shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        phase_next     = PH_WH;
      end
      PH_WH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_WL;
      end
      PH_WL: begin
        scl_level_next = 1'b0;
        if (bit_counter == LAST_BIT) begin
          done = 1'b1;
        end else begin
          bit_counter_next = bit_counter + 3'd1;
          phase_next       = PH_WD;
        end
      end
      PH_RH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_RL;
      end
      PH_RL: begin
        shift_reg_next = {shift_reg[6:0], sda_in};
        scl_level_next = 1'b0;
        if (bit_counter == LAST_BIT) begin
          done  = 1'b1;
          rdata = {shift_reg[6:0], sda_in};
        end else begin
          bit_counter_next = bit_counter + 3'd1;
          phase_next       = PH_RH;
        end
      end
      default: begin
        phase_next       = PH_IDLE;
        command_reg_next = OP_NONE;
      end
    endcase
    if (done) begin
      phase_next       = PH_IDLE;
      command_reg_next = OP_NONE;
    end
  end

  always_comb begin
    res.scl_out   = scl_level_next;
    res.sda_out   = sda_level_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.error     = err;
    res.read_data = rdata;
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign take     = out_valid && m_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(DATA_W - $bits(result_t)){1'b0}}, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_limit <= ACK_TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      ack_timeout_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      command_reg  <= OP_NONE;
      bit_counter  <= 3'd0;
      shift_reg    <= 8'd0;
      wait_counter <= 8'd0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
    end else if (accept) begin
      phase        <= phase_next;
      command_reg  <= command_reg_next;
      bit_counter  <= bit_counter_next;
      shift_reg    <= shift_reg_next;
      wait_counter <= wait_counter_next;
      scl_level    <= scl_level_next;
      sda_level    <= sda_level_next;
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid) begin
      out_res <= skid_res;
    end else if (accept && (take || !out_valid)) begin
      out_res <= res;
    end
    if (accept && out_valid && !take) begin
      skid_res <= res;
    end
  end

endmodule
